/* rtl/nti_pkg.sv */
// Shared constants, codes and types of the Neville table interpolator.
// Used by every module of the block; depends on nothing else.
package nti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_ORDER   = 7;
    localparam int SAMPLE_BITS = 24;

    localparam int TAB_AW     = $clog2(TABLE_DEPTH);
    localparam int CELL_COUNT = MAX_ORDER + 1;
    localparam int CIDX_W     = $clog2(MAX_ORDER + 1);
    localparam int STEP_W     = $clog2(2 * MAX_ORDER + 1);
    localparam int ORD_W      = 3;
    localparam int IDX_W      = 10;
    localparam int IC_W       = 10;
    localparam int POS_W      = 32;
    localparam int REG_W      = 32;
    localparam int TB_W       = 42;
    localparam int XQ_W       = CIDX_W + 16;
    localparam int DIV_BYTES  = 6;

    localparam int PH_W     = 4;
    localparam int PH_DIFF  = 0;
    localparam int PH_LO    = 1;
    localparam int PH_HI    = 2;
    localparam int PH_SUM   = 3;
    localparam int PH_ABS   = 4;
    localparam int PH_DIV   = 5;
    localparam int PH_END   = PH_DIV + DIV_BYTES;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] SEL_VALUE  = 2'd0;
    localparam logic [1:0] SEL_FIRST  = 2'd1;
    localparam logic [1:0] SEL_SECOND = 2'd2;
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DISABLED = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [2:0] REG_ORDER   = 3'd0;
    localparam logic [2:0] REG_ENABLE  = 3'd1;
    localparam logic [2:0] REG_ORIGIN  = 3'd2;
    localparam logic [2:0] REG_RECIP   = 3'd3;
    localparam logic [2:0] REG_INTERVS = 3'd4;

    typedef struct packed {
        logic              run;
        logic [PH_W-1:0]   ph;
        logic [STEP_W-1:0] step;
        logic [CIDX_W-1:0] order;
        logic [XQ_W-1:0]   xq;
    } ctl_t;

    typedef struct packed {
        logic              done;
        logic              oor;
        logic [IC_W-1:0]   start;
        logic [XQ_W-1:0]   xq;
    } map_res_t;

endpackage

/* rtl/nti_cell.sv */
// One tableau cell of the Neville chain: holds one entry for one part.
// Depends on nti_pkg; takes the entry of its right-hand neighbour.
module nti_cell (
    input  logic                                    clk,
    input  nti_pkg::ctl_t                           ctl,
    input  logic [nti_pkg::CIDX_W-1:0]              cell_idx,
    input  logic signed [nti_pkg::TB_W-1:0]         nbr,
    input  logic signed [nti_pkg::SAMPLE_BITS-1:0]  sample,
    output logic signed [nti_pkg::TB_W-1:0]         tb
);
    localparam int TBW   = nti_pkg::TB_W;
    localparam int SW    = nti_pkg::STEP_W;
    localparam int CW    = nti_pkg::CIDX_W;
    localparam int PW    = nti_pkg::PH_W;
    localparam int D_W   = TBW + 1;
    localparam int LO_W  = 22;
    localparam int HI_W  = D_W - LO_W;
    localparam int W_W   = nti_pkg::XQ_W + 2;
    localparam int PLO_W = LO_W + 1 + W_W;
    localparam int PHI_W = HI_W + W_W;
    localparam int NUM_W = PHI_W + LO_W;
    localparam int MAG_W = 8 * nti_pkg::DIV_BYTES;
    localparam int SUM_W = MAG_W + 1;
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(64'sd1 <<< 40);
    localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;

    logic signed [D_W-1:0]   d_reg;
    logic signed [W_W-1:0]   w_reg;
    logic signed [PLO_W-1:0] plo_reg;
    logic signed [PHI_W-1:0] phi_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [CW-1:0]           rem_reg;
    logic [MAG_W-1:0]        q_reg;
    logic signed [TBW-1:0]   tb_reg;

    logic [SW:0]             sum_si;
    logic [SW-1:0]           row;
    logic                    act;
    logic                    ld;
    logic [CW-1:0]           kk;
    logic signed [W_W-1:0]   w_next;
    logic [NUM_W-1:0]        abs_num;
    logic [CW:0]             r4;
    logic [CW-1:0]           r;
    logic [7:0]              qb;
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] upd;
    logic signed [TBW-1:0]   tb_next;

    assign sum_si = {1'b0, ctl.step} + (SW + 1)'(cell_idx);
    assign row    = sum_si[SW:1];
    assign act    = ctl.run && !sum_si[0] && (row > SW'(cell_idx)) && (row <= SW'(ctl.order));
    assign ld     = ctl.run && (ctl.step == SW'(cell_idx)) && (cell_idx <= ctl.order);
    assign kk     = CW'(row - SW'(cell_idx));
    assign w_next = $signed({2'b00, ctl.xq}) - $signed({2'b00, CW'(row), 16'd0});
    assign abs_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    // Long division of one byte by the small row distance.
    always_comb
    begin
        r  = rem_reg;
        qb = '0;
        r4 = '0;
        for (int b = 7; b >= 0; b--)
        begin
            r4 = {r, mag_reg[MAG_W-8+b]};
            if (r4 >= {1'b0, kk})
            begin
                r4    = r4 - {1'b0, kk};
                qb[b] = 1'b1;
            end
            r = r4[CW-1:0];
        end
    end

    always_comb
    begin
        qs  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        upd = SUM_W'(nbr) + qs;
        if (upd > LIM_HI)
        begin
            tb_next = TBW'(LIM_HI);
        end
        else if (upd < LIM_LO)
        begin
            tb_next = TBW'(LIM_LO);
        end
        else
        begin
            tb_next = TBW'(upd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ph == PW'(nti_pkg::PH_DIFF))
        begin
            d_reg <= D_W'(nbr) - D_W'(tb_reg);
            w_reg <= w_next;
        end
        if (ctl.ph == PW'(nti_pkg::PH_LO))
        begin
            plo_reg <= PLO_W'($signed({1'b0, d_reg[LO_W-1:0]})) * PLO_W'(w_reg);
        end
        if (ctl.ph == PW'(nti_pkg::PH_HI))
        begin
            phi_reg <= PHI_W'($signed(d_reg[D_W-1:LO_W])) * PHI_W'(w_reg);
        end
        if (ctl.ph == PW'(nti_pkg::PH_SUM))
        begin
            num_reg <= (NUM_W'(phi_reg) <<< LO_W) + NUM_W'(plo_reg);
        end
        if (ctl.ph == PW'(nti_pkg::PH_ABS))
        begin
            neg_reg <= num_reg[NUM_W-1];
            mag_reg <= abs_num[NUM_W-1:16];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (ctl.ph >= PW'(nti_pkg::PH_DIV) && ctl.ph < PW'(nti_pkg::PH_END))
        begin
            mag_reg <= mag_reg << 8;
            rem_reg <= r;
            q_reg   <= {q_reg[MAG_W-9:0], qb};
        end
        if (ctl.ph == PW'(nti_pkg::PH_END))
        begin
            if (ld)
            begin
                tb_reg <= TBW'(sample);
            end
            else if (act)
            begin
                tb_reg <= tb_next;
            end
        end
    end

    assign tb = tb_reg;

endmodule

/* rtl/nti_map.sv */
// Position mapping: turns a query position into a start index, offset and range flag.
// Depends on nti_pkg; a registered pipeline started by go.
module nti_map (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic signed [nti_pkg::POS_W-1:0] position,
    input  logic signed [nti_pkg::POS_W-1:0] grid_origin,
    input  logic [nti_pkg::REG_W-1:0]        step_recip,
    input  logic [nti_pkg::IC_W-1:0]         interval_count,
    input  logic [nti_pkg::CIDX_W-1:0]       order,
    output nti_pkg::map_res_t                res
);
    localparam int ICW = nti_pkg::IC_W;
    localparam int XW  = nti_pkg::XQ_W;

    logic [7:0]         vld_reg;
    logic signed [32:0] diff_reg;
    logic               neg_reg;
    logic [32:0]        mag_reg;
    logic [48:0]        p0_reg;
    logic [48:0]        p1_reg;
    logic [63:0]        t_reg;
    logic               oor_reg;
    logic [ICW-1:0]     fl_reg;
    logic [25:0]        t16_reg;
    logic [ICW-1:0]     start_reg;
    logic [XW-1:0]      xq_reg;

    logic [31:0]        hi;
    logic [31:0]        nq_hi;
    logic               oor_next;
    logic               wrap;
    logic signed [11:0] st;
    logic signed [11:0] lim;
    logic signed [11:0] st_c;

    assign hi       = t_reg[63:32];
    assign nq_hi    = 32'(interval_count);
    assign oor_next = (neg_reg && t_reg != 64'd0) || (hi > nq_hi)
                      || (hi == nq_hi && t_reg[31:0] != 32'd0);
    assign wrap     = neg_reg || (hi == nq_hi && t_reg[31:0] == 32'd0);

    always_comb
    begin
        st   = $signed({2'b00, fl_reg}) - $signed(12'(order >> 1));
        lim  = $signed({2'b00, interval_count}) - $signed(12'(order));
        st_c = st;
        if (st_c > lim)
        begin
            st_c = lim;
        end
        if (st_c < 12'sd0)
        begin
            st_c = 12'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= 33'(position) - 33'(grid_origin);
        neg_reg   <= diff_reg[32];
        mag_reg   <= diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        p0_reg    <= 49'(mag_reg) * 49'(step_recip[15:0]);
        p1_reg    <= 49'(mag_reg) * 49'(step_recip[31:16]);
        t_reg     <= 64'(p0_reg) + {p1_reg[47:0], 16'd0};
        oor_reg   <= oor_next;
        fl_reg    <= wrap ? '0 : hi[ICW-1:0];
        t16_reg   <= wrap ? '0 : t_reg[41:16];
        start_reg <= st_c[ICW-1:0];
        xq_reg    <= XW'(t16_reg - {start_reg, 16'd0});
    end

    assign res.done  = vld_reg[7];
    assign res.oor   = oor_reg;
    assign res.start = start_reg;
    assign res.xq    = xq_reg;

endmodule

/* rtl/neville_table_interpolator_unit.sv */
// Neville table interpolator: three complex sample tables and a chain of cells per part.
// Depends on nti_pkg, nti_map and nti_cell.
// A load request writes one table entry and leaves the block ready for the next request.
// A query request holds the block for the accepting cycle, the position mapping, 2n+1
// tableau steps for a polynomial of degree n (the reset degree is 3) and the write into
// the output register. In each step every cell forms a difference, a split multiply of the
// low and high parts with their sum, a magnitude, a byte-wise division of the 48-bit
// magnitude and the update. A query for a table that is not enabled or does not exist goes
// from the accepting cycle straight to the output register; one whose position is out of
// range goes there after the position mapping. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken, and a
// further result waits until that register is free. Table entries that were never loaded
// read as unknown data.
module neville_table_interpolator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_index, sample_re, sample_im, position, zero padding
    input  logic [95:0] s_tdata,
    // op, table_sel
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_re, result_im
    output logic [47:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int SB  = nti_pkg::SAMPLE_BITS;
    localparam int AW  = nti_pkg::TAB_AW;
    localparam int CC  = nti_pkg::CELL_COUNT;
    localparam int CW  = nti_pkg::CIDX_W;
    localparam int SW  = nti_pkg::STEP_W;
    localparam int PW  = nti_pkg::PH_W;
    localparam int ICW = nti_pkg::IC_W;
    localparam int TBW = nti_pkg::TB_W;
    localparam logic signed [TBW-1:0] OUT_MAX = TBW'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [TBW-1:0] OUT_MIN = -OUT_MAX - 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAP  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             poly_order_reg;
    logic [1:0]             tables_enabled_reg;
    logic signed [31:0]     grid_origin_reg;
    logic [31:0]            step_recip_reg;
    logic [ICW-1:0]         interval_count_reg;

    logic [1:0]             sel_reg;
    logic signed [31:0]     pos_reg;
    logic [ICW-1:0]         start_reg;
    logic [nti_pkg::XQ_W-1:0] xq_reg;
    logic [SW-1:0]          step_reg;
    logic [PW-1:0]          ph_reg;
    logic [1:0]             pend_status_reg;
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;
    logic [1:0]             m_tuser_reg;

    logic [2*SB-1:0]        val_mem [nti_pkg::TABLE_DEPTH];
    logic [2*SB-1:0]        fd_mem  [nti_pkg::TABLE_DEPTH];
    logic [2*SB-1:0]        sd_mem  [nti_pkg::TABLE_DEPTH];
    logic [2*SB-1:0]        val_rd_reg;
    logic [2*SB-1:0]        fd_rd_reg;
    logic [2*SB-1:0]        sd_rd_reg;
    logic [2*SB-1:0]        rd_data;

    logic                   acc;
    logic                   in_op;
    logic [1:0]             in_sel;
    logic [nti_pkg::IDX_W-1:0] in_idx;
    logic                   sel_bad;
    logic [CW-1:0]          order_eff;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   step_last;
    logic                   out_free;
    logic                   map_go;
    nti_pkg::map_res_t      map_res;
    nti_pkg::ctl_t          ctl;
    logic signed [TBW-1:0]  tb_re [CC];
    logic signed [TBW-1:0]  tb_im [CC];
    logic signed [SB-1:0]   res_re;
    logic signed [SB-1:0]   res_im;

    assign acc    = s_tvalid && s_tready;
    assign in_op  = s_tuser[0];
    assign in_sel = s_tuser[2:1];
    assign in_idx = s_tdata[9:0];
    assign s_tready = (state_reg == ST_IDLE);

    assign sel_bad = (in_sel != nti_pkg::SEL_VALUE && in_sel != nti_pkg::SEL_FIRST
                      && in_sel != nti_pkg::SEL_SECOND)
                     || (in_sel == nti_pkg::SEL_FIRST && !tables_enabled_reg[0])
                     || (in_sel == nti_pkg::SEL_SECOND && !tables_enabled_reg[1]);

    assign order_eff = (int'(poly_order_reg) > nti_pkg::MAX_ORDER)
                       ? CW'(nti_pkg::MAX_ORDER) : CW'(poly_order_reg);
    assign step_last = (step_reg == SW'({order_eff, 1'b0}));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign map_go    = acc && in_op == nti_pkg::OP_QUERY && !sel_bad;
    assign rd_en     = (state_reg == ST_RUN) && ph_reg == PW'(nti_pkg::PH_DIFF)
                       && step_reg <= SW'(order_eff);
    assign rd_addr   = AW'({1'b0, start_reg} + (ICW + 1)'(step_reg));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_order_reg     <= 3'd3;
            tables_enabled_reg <= 2'd0;
            grid_origin_reg    <= '0;
            step_recip_reg     <= 32'd65536;
            interval_count_reg <= 10'd1023;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nti_pkg::REG_ORDER:   poly_order_reg     <= cfg_data[2:0];
                nti_pkg::REG_ENABLE:  tables_enabled_reg <= cfg_data[1:0];
                nti_pkg::REG_ORIGIN:  grid_origin_reg    <= cfg_data;
                nti_pkg::REG_RECIP:   step_recip_reg     <= cfg_data;
                nti_pkg::REG_INTERVS: interval_count_reg <= cfg_data[ICW-1:0];
                default: ;
            endcase
        end
    end

    // Sample tables.
    always_ff @(posedge clk)
    begin
        if (acc && in_op == nti_pkg::OP_LOAD && int'(in_idx) < nti_pkg::TABLE_DEPTH)
        begin
            case (in_sel)
                nti_pkg::SEL_VALUE:  val_mem[AW'(in_idx)] <= {s_tdata[57:34], s_tdata[33:10]};
                nti_pkg::SEL_FIRST:  fd_mem[AW'(in_idx)]  <= {s_tdata[57:34], s_tdata[33:10]};
                nti_pkg::SEL_SECOND: sd_mem[AW'(in_idx)]  <= {s_tdata[57:34], s_tdata[33:10]};
                default: ;
            endcase
        end
        if (rd_en)
        begin
            val_rd_reg <= val_mem[rd_addr];
            fd_rd_reg  <= fd_mem[rd_addr];
            sd_rd_reg  <= sd_mem[rd_addr];
        end
    end

    always_comb
    begin
        case (sel_reg)
            nti_pkg::SEL_FIRST:  rd_data = fd_rd_reg;
            nti_pkg::SEL_SECOND: rd_data = sd_rd_reg;
            default:             rd_data = val_rd_reg;
        endcase
    end

    nti_map u_map (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (map_go),
        .position       (pos_reg),
        .grid_origin    (grid_origin_reg),
        .step_recip     (step_recip_reg),
        .interval_count (interval_count_reg),
        .order          (order_eff),
        .res            (map_res)
    );

    assign ctl.run   = (state_reg == ST_RUN);
    assign ctl.ph    = ph_reg;
    assign ctl.step  = step_reg;
    assign ctl.order = order_eff;
    assign ctl.xq    = xq_reg;

    for (genvar c = 0; c < CC; c++)
    begin : g_cell
        logic signed [TBW-1:0] nbr_re;
        logic signed [TBW-1:0] nbr_im;
        if (c == CC - 1)
        begin : g_end
            assign nbr_re = '0;
            assign nbr_im = '0;
        end
        else
        begin : g_mid
            assign nbr_re = tb_re[c+1];
            assign nbr_im = tb_im[c+1];
        end
        nti_cell u_re (
            .clk      (clk),
            .ctl      (ctl),
            .cell_idx (CW'(c)),
            .nbr      (nbr_re),
            .sample   (rd_data[SB-1:0]),
            .tb       (tb_re[c])
        );
        nti_cell u_im (
            .clk      (clk),
            .ctl      (ctl),
            .cell_idx (CW'(c)),
            .nbr      (nbr_im),
            .sample   (rd_data[2*SB-1:SB]),
            .tb       (tb_im[c])
        );
    end

    always_comb
    begin
        if (tb_re[0] > OUT_MAX)
        begin
            res_re = SB'(OUT_MAX);
        end
        else if (tb_re[0] < OUT_MIN)
        begin
            res_re = SB'(OUT_MIN);
        end
        else
        begin
            res_re = SB'(tb_re[0]);
        end
        if (tb_im[0] > OUT_MAX)
        begin
            res_im = SB'(OUT_MAX);
        end
        else if (tb_im[0] < OUT_MIN)
        begin
            res_im = SB'(OUT_MIN);
        end
        else
        begin
            res_im = SB'(tb_im[0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_op == nti_pkg::OP_QUERY)
                begin
                    state_next = sel_bad ? ST_OUT : ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (map_res.done)
                begin
                    state_next = map_res.oor ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (ph_reg == PW'(nti_pkg::PH_END) && step_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            ph_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
            begin
                if (ph_reg == PW'(nti_pkg::PH_END))
                begin
                    ph_reg   <= '0;
                    step_reg <= step_reg + SW'(1);
                end
                else
                begin
                    ph_reg <= ph_reg + PW'(1);
                end
            end
            else
            begin
                ph_reg   <= '0;
                step_reg <= '0;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            sel_reg         <= in_sel;
            pos_reg         <= s_tdata[89:58];
            pend_status_reg <= nti_pkg::STATUS_DISABLED;
        end
        if (state_reg == ST_MAP && map_res.done)
        begin
            start_reg       <= map_res.start;
            xq_reg          <= map_res.xq;
            pend_status_reg <= map_res.oor ? nti_pkg::STATUS_RANGE : nti_pkg::STATUS_OK;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= (pend_status_reg == nti_pkg::STATUS_OK) ? {res_im, res_re} : '0;
            m_tuser_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == nti_pkg::STATUS_OK || m_tuser == nti_pkg::STATUS_DISABLED
                      || m_tuser == nti_pkg::STATUS_RANGE))
        else $error("result carries an unknown status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != nti_pkg::STATUS_OK) |-> (m_tdata == 48'd0))
        else $error("flagged result carries non-zero data");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= SW'({order_eff, 1'b0})
                                   && ph_reg <= PW'(nti_pkg::PH_END)))
        else $error("tableau sequencer ran past the last step");

    a_map_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !s_tready)
        else $error("request taken while the tableau is busy");

endmodule
